@@ hw/rtl/wgs_pkg.sv @@
// Shared constants, register indexes and the sine table generator for the
// wind gust block. Depends on nothing.
package wgs_pkg;

  localparam int unsigned NumWaves = 8;

  // Wave order: north 0..2, east 3..5, down 6..7. Values are cycles per second
  // and phase offsets, both in Q0.32 turns.
  localparam logic [31:0] WAVE_FREQ [NumWaves] = '{
    32'd205069583, 32'd526345262, 32'd1250924454,
    32'd273426110, 32'd635715706, 32'd1483336648,
    32'd239247846, 32'd751921803
  };
  localparam logic [31:0] WAVE_OFFS [NumWaves] = '{
    32'd683565276, 32'd2529191520, 32'd341782638,
    32'd1572200134, 32'd3486182905, 32'd820278331,
    32'd2734261102, 32'd1913982772
  };

  localparam logic [2:0] REG_BASE_NORTH = 3'd0;
  localparam logic [2:0] REG_BASE_EAST  = 3'd1;
  localparam logic [2:0] REG_BASE_DOWN  = 3'd2;
  localparam logic [2:0] REG_INTENSITY  = 3'd3;
  localparam logic [2:0] REG_ENABLE     = 3'd4;

  // Reciprocals for exact division by 75 and by 100 (multiply, shift by 38).
  localparam logic [31:0] RECIP_75  = 32'd3665038760;
  localparam logic [31:0] RECIP_100 = 32'd2748779070;

  // Quarter sine in Q1.15 from an odd Taylor series in Q30, evaluated at
  // elaboration to fill the lookup table.
  function automatic logic [14:0] quarter_sine(int unsigned r, int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    longint unsigned s;
    logic [127:0] recip;
    logic [127:0] quot;
    x  = (64'(r) * 64'd1686629713) >> (bits - 2);
    x2 = (x * x) >> 30;
    t  = 64'd1073741824;
    for (int i = 0; i < 5; i++) begin
      // Series divisors 110, 72, 42, 20 and 6 as ceil(2^39 / d); the dividend
      // stays below 2^32, so the quotient is exact.
      case (i)
        0:       recip = 128'd4997780127;
        1:       recip = 128'd7635497416;
        2:       recip = 128'd13089424141;
        3:       recip = 128'd27487790695;
        default: recip = 128'd91625968982;
      endcase
      quot = (128'((x2 * t) >> 30) * recip) >> 39;
      t = 64'd1073741824 - quot[63:0];
    end
    y = (x * t) >> 30;
    s = (y * 64'd32767 + 64'd536870912) >> 30;
    if (s > 64'd32767) s = 64'd32767;
    return s[14:0];
  endfunction

endpackage

@@ hw/rtl/wgs_sine_bank.sv @@
// Two-stage bank of eight sine generators: phase multiply, then table lookup.
// Depends on wgs_pkg.
module wgs_sine_bank import wgs_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic [31:0]              query_time_i,
  output logic signed [15:0]       sine_o [NumWaves]
);

  localparam int unsigned QLen = 1 << (SINE_TABLE_BITS - 2);

  logic [14:0] lut [QLen+1];
  logic [31:0] phase_q [NumWaves];
  logic signed [15:0] sine_q [NumWaves];

  for (genvar g = 0; g <= QLen; g++) begin : g_lut
    assign lut[g] = quarter_sine(g, SINE_TABLE_BITS);
  end

  for (genvar w = 0; w < NumWaves; w++) begin : g_wave
    logic [63:0] prod;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS-2:0] r;
    logic [14:0] mag;

    assign prod = 64'(query_time_i) * 64'(WAVE_FREQ[w]);
    assign idx  = phase_q[w][31 -: SINE_TABLE_BITS];

    always_comb begin
      if (idx[SINE_TABLE_BITS-2]) begin
        r = (SINE_TABLE_BITS-1)'(QLen) - {1'b0, idx[SINE_TABLE_BITS-3:0]};
      end else begin
        r = {1'b0, idx[SINE_TABLE_BITS-3:0]};
      end
      mag = lut[r];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        phase_q[w] <= '0;
        sine_q[w]  <= '0;
      end else if (adv_i) begin
        phase_q[w] <= prod[47:16] + WAVE_OFFS[w];
        sine_q[w]  <= idx[SINE_TABLE_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
    end

    assign sine_o[w] = sine_q[w];
  end

endmodule

@@ hw/rtl/wgs_alt_factor.sv @@
// Three-stage altitude factor in unsigned Q8.16: subtract, reciprocal
// multiply, select. Depends on wgs_pkg.
module wgs_alt_factor import wgs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic signed [21:0] altitude_i,
  output logic [23:0]        factor_o
);

  logic signed [38:0] num;
  logic [30:0] num_q;
  logic        high_q;
  logic        high2_q;
  logic [62:0] prod_q;
  logic [23:0] factor_q;

  // Numerator divided by 128 first; the remaining divide by 75 is exact.
  assign num = 39'sd943723200 - (39'(altitude_i) <<< 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q    <= '0;
      high_q   <= 1'b0;
      high2_q  <= 1'b0;
      prod_q   <= '0;
      factor_q <= '0;
    end else if (adv_i) begin
      num_q    <= num[37:7];
      high_q   <= altitude_i >= 22'sd4800;
      prod_q   <= 63'(num_q) * 63'(RECIP_75);
      high2_q  <= high_q;
      factor_q <= high2_q ? 24'd65536 : prod_q[61:38];
    end
  end

  assign factor_o = factor_q;

endmodule

@@ hw/rtl/wgs_gust_scale.sv @@
// Four-stage gust magnitude for one axis: intensity, factor in two halves,
// rounding and divide by 100*2^31. Depends on wgs_pkg.
module wgs_gust_scale import wgs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic signed [22:0] sum_i,
  input  logic [15:0]        intensity_i,
  input  logic [23:0]        factor_i,
  output logic [24:0]        gust_mag_o,
  output logic               neg_o
);

  logic [21:0] mag;
  logic [37:0] mi_q;
  logic [23:0] f_q;
  logic [49:0] plo_q, phi_q;
  logic [31:0] n_q;
  logic [62:0] prod_q;
  logic [62:0] total;
  logic [3:0]  neg_q;

  assign mag   = sum_i[22] ? 22'(-sum_i) : sum_i[21:0];
  assign total = (63'(phi_q) << 12) + 63'(plo_q) + 63'd107374182400;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mi_q   <= '0;
      f_q    <= '0;
      plo_q  <= '0;
      phi_q  <= '0;
      n_q    <= '0;
      prod_q <= '0;
      neg_q  <= '0;
    end else if (adv_i) begin
      mi_q   <= 38'(mag) * 38'(intensity_i);
      f_q    <= factor_i;
      plo_q  <= 50'(mi_q) * 50'(f_q[11:0]);
      phi_q  <= 50'(mi_q) * 50'(f_q[23:12]);
      n_q    <= total[62:31];
      prod_q <= 63'(n_q) * 63'(RECIP_100);
      neg_q  <= {neg_q[2:0], sum_i[22]};
    end
  end

  assign gust_mag_o = prod_q[62:38];
  assign neg_o      = neg_q[3];

endmodule

@@ hw/rtl/wind_gust_sine_sum.sv @@
// Top level of the wind gust block: configuration registers, sine sums and
// the output stage. Depends on wgs_pkg, wgs_sine_bank, wgs_alt_factor, wgs_gust_scale.
//
// Eight-stage pipeline that takes one query per cycle; all stages advance
// together, held only while the output register waits on m_axis_tready.
// Configuration writes are always accepted and apply to every item in
// flight, so write them while idle.
module wind_gust_sine_sum import wgs_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // altitude [21:0], query time [53:22], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // wind_north [15:0], wind_east [31:16], wind_down [47:32]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned Depth = 8;

  logic signed [15:0] base_q [3];
  logic [15:0] intensity_q;
  logic        enable_q;
  logic [Depth-1:0] valid_q;
  logic adv;

  logic signed [15:0] sine [NumWaves];
  logic [23:0] factor;
  logic signed [22:0] sum_q [3];
  logic [24:0] gust_mag [3];
  logic [2:0]  gust_neg;
  logic [15:0] wind_q [3];

  assign adv           = !valid_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q[0]   <= '0;
      base_q[1]   <= '0;
      base_q[2]   <= '0;
      intensity_q <= '0;
      enable_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BASE_NORTH: base_q[0]   <= cfg_data_i;
        REG_BASE_EAST:  base_q[1]   <= cfg_data_i;
        REG_BASE_DOWN:  base_q[2]   <= cfg_data_i;
        REG_INTENSITY:  intensity_q <= cfg_data_i;
        REG_ENABLE:     enable_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[Depth-2:0], s_axis_tvalid};
    end
  end

  wgs_sine_bank #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (
    .clk_i, .rst_ni, .adv_i(adv),
    .query_time_i(s_axis_tdata[53:22]),
    .sine_o(sine)
  );

  wgs_alt_factor u_alt (
    .clk_i, .rst_ni, .adv_i(adv),
    .altitude_i(s_axis_tdata[21:0]),
    .factor_o(factor)
  );

  // Weighted sums in hundredths of Q15; down carries the half scale.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      sum_q[2] <= '0;
    end else if (adv) begin
      sum_q[0] <= 23'(sine[0]) * 23'sd50 + 23'(sine[1]) * 23'sd30 + 23'(sine[2]) * 23'sd20;
      sum_q[1] <= 23'(sine[3]) * 23'sd50 + 23'(sine[4]) * 23'sd30 + 23'(sine[5]) * 23'sd20;
      sum_q[2] <= 23'(sine[6]) * 23'sd30 + 23'(sine[7]) * 23'sd20;
    end
  end

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    logic signed [26:0] gust;
    logic signed [26:0] total;

    wgs_gust_scale u_scale (
      .clk_i, .rst_ni, .adv_i(adv),
      .sum_i(sum_q[ax]),
      .intensity_i(intensity_q),
      .factor_i(factor),
      .gust_mag_o(gust_mag[ax]),
      .neg_o(gust_neg[ax])
    );

    always_comb begin
      gust = gust_neg[ax] ? -$signed({2'b00, gust_mag[ax]}) : $signed({2'b00, gust_mag[ax]});
      if (!enable_q || intensity_q == '0) begin
        gust = '0;
      end
      total = 27'(base_q[ax]) + gust;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        wind_q[ax] <= '0;
      end else if (adv) begin
        if (total > 27'sd32767) begin
          wind_q[ax] <= 16'h7fff;
        end else if (total < -27'sd32768) begin
          wind_q[ax] <= 16'h8000;
        end else begin
          wind_q[ax] <= total[15:0];
        end
      end
    end
  end

  assign m_axis_tvalid = valid_q[Depth-1];
  assign m_axis_tdata  = {wind_q[2], wind_q[1], wind_q[0]};

`ifndef ASSERT_OFF
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(valid_q))
    else $error("pipeline valid bits moved during a stall");
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> valid_q[0])
    else $error("accepted request did not enter the pipeline");
`endif

endmodule
